>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of the nearest-site cell box block.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define NSCB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define NSCB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nscb_pkg.sv
// Package for the nearest-site cell box block: widths, stream field offsets, codes,
// shared structs and arithmetic helpers. Depends on nothing.
`default_nettype none

package nscb_pkg;

  // Field widths.
  localparam int COORD_W       = 24;
  localparam int SIDX_W        = 6;
  localparam int REQ_W         = 2;
  localparam int REACH_W       = 23;
  localparam int COUNT_W       = 7;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W + 1;
  localparam int DIST_W        = 50;
  localparam int AREA_W        = 49;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = COORD_W;
  localparam int DEF_MAX_SITES = 64;

  localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(256000);

  // Input stream layout: tdata = site_index, point_x, point_y; tuser = req_type.
  localparam int I_IDX_LSB  = 0;
  localparam int I_X_LSB    = I_IDX_LSB + SIDX_W;
  localparam int I_Y_LSB    = I_X_LSB + COORD_W;
  localparam int I_END      = I_Y_LSB + COORD_W;
  localparam int IN_TDATA_W = ((I_END + 7) / 8) * 8;

  // Output stream layout; tuser carries box_filled.
  localparam int O_SITE_LSB  = 0;
  localparam int O_DIST_LSB  = O_SITE_LSB + SIDX_W;
  localparam int O_MINX_LSB  = O_DIST_LSB + DIST_W;
  localparam int O_MAXX_LSB  = O_MINX_LSB + COORD_W;
  localparam int O_MINY_LSB  = O_MAXX_LSB + COORD_W;
  localparam int O_MAXY_LSB  = O_MINY_LSB + COORD_W;
  localparam int O_CX_LSB    = O_MAXY_LSB + COORD_W;
  localparam int O_CY_LSB    = O_CX_LSB + COORD_W;
  localparam int O_AREA_LSB  = O_CY_LSB + COORD_W;
  localparam int O_FAR_LSB   = O_AREA_LSB + AREA_W;
  localparam int O_REACH_BIT = O_FAR_LSB + DIST_W;
  localparam int O_END       = O_REACH_BIT + 1;
  localparam int OUT_TDATA_W = ((O_END + 7) / 8) * 8;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_LEFT   = 3'd0,
    CFG_BOUND_TOP    = 3'd1,
    CFG_BOUND_RIGHT  = 3'd2,
    CFG_BOUND_BOTTOM = 3'd3,
    CFG_REACH_LIMIT  = 3'd4,
    CFG_SITE_COUNT   = 3'd5
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CELL_RD,
    S_CELL_WR,
    S_RD_ISSUE,
    S_RD_START,
    S_RD_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } site_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
  } cell_t;

  // Operands handed to the readout arithmetic.
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    cell_t                     box;
    logic [REACH_W-1:0]        reach;
  } cm_in_t;

  // Readout fields returned by the readout arithmetic.
  typedef struct packed {
    cell_t                     box;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [AREA_W-1:0]         area;
    logic [DIST_W-1:0]         far;
    logic                      reach_ok;
  } cm_out_t;

  // Magnitude of the difference of two signed coordinates.
  function automatic logic [DIFF_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(~d + 1'b1) : DIFF_W'(d);
  endfunction

  // Midpoint of two signed coordinates, rounded toward minus infinity.
  function automatic logic signed [COORD_W-1:0] midpoint(input logic signed [COORD_W-1:0] a,
                                                         input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] s;
    s = DIFF_W'(a) + DIFF_W'(b);
    return s[DIFF_W-1:1];
  endfunction

endpackage

`default_nettype wire

>>> rtl/nscb_cell_math.sv
// Readout arithmetic: box size, midpoint, area, farthest corner distance and reach test.
// Four register stages with one pass of multipliers. Depends on nscb_pkg.
`default_nettype none

module nscb_cell_math (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  nscb_pkg::cm_in_t in_ops,
  output logic             out_valid,
  output nscb_pkg::cm_out_t out_res
);
  import nscb_pkg::*;

  logic              a_v, b_v, c_v, d_v;
  cell_t             a_box;
  logic signed [COORD_W-1:0] a_cx, a_cy;
  logic [REACH_W-1:0] a_reach, b_reach;
  logic [DIFF_W-1:0] a_wx, a_hy, a_dx0, a_dx1, a_dy0, a_dy1;
  logic [DIFF_W-1:0] b_wx, b_hy, b_mdx, b_mdy;
  logic [AREA_W-1:0] c_area;
  logic [SQ_W-1:0]   c_sqx, c_sqy;
  logic [2*REACH_W-1:0] c_rsq;
  logic [DIST_W-1:0] d_far;
  logic              d_within;
  logic [2*DIFF_W-1:0] area_full, sqx_full, sqy_full;
  logic [DIST_W-1:0] far_sum;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  // Stage A: edge lengths, distances from the site to each edge, midpoints.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      a_box   <= in_ops.box;
      a_reach <= in_ops.reach;
      a_wx    <= absdiff(in_ops.box.max_x, in_ops.box.min_x);
      a_hy    <= absdiff(in_ops.box.max_y, in_ops.box.min_y);
      a_dx0   <= absdiff(in_ops.sx, in_ops.box.min_x);
      a_dx1   <= absdiff(in_ops.sx, in_ops.box.max_x);
      a_dy0   <= absdiff(in_ops.sy, in_ops.box.min_y);
      a_dy1   <= absdiff(in_ops.sy, in_ops.box.max_y);
      a_cx    <= midpoint(in_ops.box.min_x, in_ops.box.max_x);
      a_cy    <= midpoint(in_ops.box.min_y, in_ops.box.max_y);
    end
  end

  // Stage B: the farthest corner has the larger offset on each axis.
  always_ff @(posedge clk) begin
    if (a_v) begin
      b_wx    <= a_wx;
      b_hy    <= a_hy;
      b_reach <= a_reach;
      b_mdx   <= (a_dx0 > a_dx1) ? a_dx0 : a_dx1;
      b_mdy   <= (a_dy0 > a_dy1) ? a_dy0 : a_dy1;
    end
  end

  // Stage C: products.
  assign area_full = b_wx * b_hy;
  assign sqx_full  = b_mdx * b_mdx;
  assign sqy_full  = b_mdy * b_mdy;

  always_ff @(posedge clk) begin
    if (b_v) begin
      c_area <= area_full[AREA_W-1:0];
      c_sqx  <= sqx_full[SQ_W-1:0];
      c_sqy  <= sqy_full[SQ_W-1:0];
      c_rsq  <= b_reach * b_reach;
    end
  end

  // Stage D: corner distance and reach test.
  assign far_sum = DIST_W'(c_sqx) + DIST_W'(c_sqy);

  always_ff @(posedge clk) begin
    if (c_v) begin
      d_far    <= far_sum;
      d_within <= (far_sum <= DIST_W'(c_rsq));
    end
  end

  // Result assembly; box and midpoints stay held from stage A.
  always_comb begin
    out_res.box      = a_box;
    out_res.center_x = a_cx;
    out_res.center_y = a_cy;
    out_res.area     = c_area;
    out_res.far      = d_far;
    out_res.reach_ok = d_within;
  end

  assign out_valid = d_v;

endmodule

`default_nettype wire

>>> rtl/nearest_site_cell_boxes_top.sv
// Nearest-site labeling with per-site cell boxes: top level with site and cell memories.
// Depends on nscb_pkg and nscb_cell_math.
//
// Requests arrive on the s_axis stream, req_type in tuser: load a site, classify a sample
// point, or read out a site's cell. Results leave on the m_axis stream; box_filled is in
// tuser. Registers are written through the cfg channel, which is always ready; write them
// only while the block is idle.
// A load writes the site memory from the idle state and gives no result. A sample scans
// sites 0 to n-1, where n is site_count capped at MAX_SITES, with one site memory read per
// cycle into the distance pipeline, and the winner's cell box is updated in the cell memory
// by a read and a write back. With no sites in the search a sample is dropped. A readout
// reads both memories at one address and runs the readout arithmetic. One request is in
// work at a time; the sequencer accepts no new request until the last result is registered.
// The result sits in an output register: the next request is accepted while it waits,
// and a stalled receiver only holds the sequencer when the next result is ready.
// Reset clears the registers, the cell occupancy flags and the output; site and cell
// memory contents are undefined until loaded, so no clearing pass is needed.

`default_nettype none

module nearest_site_cell_boxes_top #(
  parameter int MAX_SITES = nscb_pkg::DEF_MAX_SITES
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nscb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nscb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Requests.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // site_index[5:0], point_x[29:6], point_y[53:30], zero fill
  input  logic [nscb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  logic [nscb_pkg::REQ_W-1:0]        s_axis_tuser,
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // nearest_site[5:0], nearest_dist_sq[55:6], box_min_x[79:56], box_max_x[103:80],
  // box_min_y[127:104], box_max_y[151:128], center_x[175:152], center_y[199:176],
  // box_area[248:200], max_corner_dist_sq[298:249], within_reach[299], zero fill
  output logic [nscb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // box_filled[0]
  output logic [0:0]                        m_axis_tuser
);
  import nscb_pkg::*;

  localparam int SITE_AW = $clog2(MAX_SITES);
  localparam int CNT_W   = $clog2(MAX_SITES + 1);

  // Configuration registers.
  logic signed [COORD_W-1:0] bound_left, bound_top, bound_right, bound_bottom;
  logic [REACH_W-1:0]        reach_limit;
  logic [COUNT_W-1:0]        site_count;

  // Sequencer and request registers.
  state_t                    state, state_next;
  req_t                      cur_req;
  logic [SITE_AW-1:0]        cur_idx;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [SITE_AW-1:0]        scan_cnt, scan_last;
  logic                      filled;

  // Input fields.
  req_t                      in_req;
  logic [SIDX_W-1:0]         in_idx_raw;
  logic [SITE_AW-1:0]        in_idx;
  logic signed [COORD_W-1:0] in_x, in_y;
  logic                      in_xfer;

  // Site count in use.
  logic [CNT_W-1:0]          n_eff, n_m1;
  logic                      n_ge2;

  // Memories and their ports.
  site_t                     site_mem [MAX_SITES];
  cell_t                     cell_mem [MAX_SITES];
  site_t                     site_rdata;
  cell_t                     cell_rdata, cell_new;
  logic                      site_we, site_re, cell_we, cell_re;
  logic [SITE_AW-1:0]        site_raddr, cell_raddr;
  logic [MAX_SITES-1:0]      has_points;

  // Distance pipeline.
  logic                      p1_v, p2_v, p3_v;
  logic [SITE_AW-1:0]        p1_i, p2_i, p3_i;
  logic [DIFF_W-1:0]         p2_dx, p2_dy;
  logic [SQ_W-1:0]           p3_sqx, p3_sqy;
  logic [2*DIFF_W-1:0]       sqx_full, sqy_full;
  logic [DIST_W-1:0]         d_sum, best_d;
  logic [SITE_AW-1:0]        best_i;

  // Readout arithmetic.
  cm_in_t                    cm_in;
  cm_out_t                   cm_out;
  logic                      cm_start, cm_done;

  // Output register.
  logic                      out_load;
  logic [OUT_TDATA_W-1:0]    out_pack;

  assign cfg_ready = 1'b1;

  // Unpack the request and reduce the site index modulo MAX_SITES.
  always_comb begin
    logic [12:0] r;
    in_req     = req_t'(s_axis_tuser);
    in_idx_raw = s_axis_tdata[I_IDX_LSB +: SIDX_W];
    in_x       = s_axis_tdata[I_X_LSB +: COORD_W];
    in_y       = s_axis_tdata[I_Y_LSB +: COORD_W];
    r          = 13'(in_idx_raw);
    for (int b = SIDX_W - 1; b >= 0; b--) begin
      if (r >= (13'(MAX_SITES) << b)) begin
        r = r - (13'(MAX_SITES) << b);
      end
    end
    in_idx = r[SITE_AW-1:0];
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Sites taking part in the search, capped at the table size.
  assign n_eff = (site_count > COUNT_W'(MAX_SITES)) ? CNT_W'(MAX_SITES)
                                                     : site_count[CNT_W-1:0];
  assign n_m1  = n_eff - CNT_W'(1);
  assign n_ge2 = (n_eff >= CNT_W'(2));

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_left   <= '0;
      bound_top    <= '0;
      bound_right  <= '0;
      bound_bottom <= '0;
      reach_limit  <= REACH_RESET;
      site_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOUND_LEFT:   bound_left   <= cfg_data;
        CFG_BOUND_TOP:    bound_top    <= cfg_data;
        CFG_BOUND_RIGHT:  bound_right  <= cfg_data;
        CFG_BOUND_BOTTOM: bound_bottom <= cfg_data;
        CFG_REACH_LIMIT:  reach_limit  <= cfg_data[REACH_W-1:0];
        CFG_SITE_COUNT:   site_count   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    site_we       = 1'b0;
    site_re       = 1'b0;
    cell_we       = 1'b0;
    cell_re       = 1'b0;
    site_raddr    = cur_idx;
    cell_raddr    = cur_idx;
    cm_start      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (in_req)
            REQ_LOAD:   site_we = 1'b1;
            REQ_SAMPLE: if (n_eff != '0) state_next = S_SCAN;
            REQ_READ:   state_next = S_RD_ISSUE;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        site_re    = 1'b1;
        site_raddr = scan_cnt;
        if (scan_cnt == scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_v && !p2_v && !p3_v) begin
          state_next = S_CELL_RD;
        end
      end
      S_CELL_RD: begin
        cell_re    = 1'b1;
        cell_raddr = best_i;
        state_next = S_CELL_WR;
      end
      S_CELL_WR: begin
        cell_we    = 1'b1;
        state_next = S_EMIT;
      end
      S_RD_ISSUE: begin
        site_re    = 1'b1;
        cell_re    = 1'b1;
        state_next = S_RD_START;
      end
      S_RD_START: begin
        cm_start   = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (cm_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Request capture and scan counter.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_req   <= in_req;
      cur_idx   <= in_idx;
      cur_x     <= in_x;
      cur_y     <= in_y;
      scan_last <= n_m1[SITE_AW-1:0];
    end
    if (in_xfer) begin
      scan_cnt <= '0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (state == S_RD_START) begin
      filled <= has_points[cur_idx] && n_ge2;
    end
  end

  // Site memory: written by loads, read by the scan and by readouts.
  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[in_idx] <= '{x: in_x, y: in_y};
    end
    if (site_re) begin
      site_rdata <= site_mem[site_raddr];
    end
  end

  // Cell memory: read-modify-write for the sample winner, read for readouts.
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[best_i] <= cell_new;
    end
    if (cell_re) begin
      cell_rdata <= cell_mem[cell_raddr];
    end
  end

  // Grow the winner's box, or start it at the sample for an empty cell.
  always_comb begin
    if (!has_points[best_i]) begin
      cell_new = '{min_x: cur_x, max_x: cur_x, min_y: cur_y, max_y: cur_y};
    end else begin
      cell_new       = cell_rdata;
      cell_new.min_x = (cur_x < cell_rdata.min_x) ? cur_x : cell_rdata.min_x;
      cell_new.max_x = (cur_x > cell_rdata.max_x) ? cur_x : cell_rdata.max_x;
      cell_new.min_y = (cur_y < cell_rdata.min_y) ? cur_y : cell_rdata.min_y;
      cell_new.max_y = (cur_y > cell_rdata.max_y) ? cur_y : cell_rdata.max_y;
    end
  end

  // Cell occupancy flags: cleared by a load, set when a sample lands in the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_points <= '0;
    end else if (site_we) begin
      has_points[in_idx] <= 1'b0;
    end else if (cell_we) begin
      has_points[best_i] <= 1'b1;
    end
  end

  // Distance pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= (state == S_SCAN);
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  assign sqx_full = p2_dx * p2_dx;
  assign sqy_full = p2_dy * p2_dy;
  assign d_sum    = DIST_W'(p3_sqx) + DIST_W'(p3_sqy);

  // Distance pipeline: offsets, squares, then compare against the best so far.
  always_ff @(posedge clk) begin
    p1_i   <= scan_cnt;
    p2_i   <= p1_i;
    p2_dx  <= absdiff(cur_x, site_rdata.x);
    p2_dy  <= absdiff(cur_y, site_rdata.y);
    p3_i   <= p2_i;
    p3_sqx <= sqx_full[SQ_W-1:0];
    p3_sqy <= sqy_full[SQ_W-1:0];
    if (p3_v && ((p3_i == '0) || (d_sum < best_d))) begin
      best_d <= d_sum;
      best_i <= p3_i;
    end
  end

  // Readout operands: the cell box, or the boundary when the cell is not shown.
  always_comb begin
    cm_in.sx    = site_rdata.x;
    cm_in.sy    = site_rdata.y;
    cm_in.reach = reach_limit;
    if (has_points[cur_idx] && n_ge2) begin
      cm_in.box = cell_rdata;
    end else begin
      cm_in.box = '{min_x: bound_left, max_x: bound_right,
                    min_y: bound_top, max_y: bound_bottom};
    end
  end

  nscb_cell_math u_cell_math (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cm_start),
    .in_ops    (cm_in),
    .out_valid (cm_done),
    .out_res   (cm_out)
  );

  // Result packing.
  always_comb begin
    out_pack = '0;
    if (cur_req == REQ_SAMPLE) begin
      out_pack[O_SITE_LSB +: SIDX_W] = SIDX_W'(best_i);
      out_pack[O_DIST_LSB +: DIST_W] = best_d;
    end else begin
      out_pack[O_SITE_LSB +: SIDX_W]  = SIDX_W'(cur_idx);
      out_pack[O_MINX_LSB +: COORD_W] = cm_out.box.min_x;
      out_pack[O_MAXX_LSB +: COORD_W] = cm_out.box.max_x;
      out_pack[O_MINY_LSB +: COORD_W] = cm_out.box.min_y;
      out_pack[O_MAXY_LSB +: COORD_W] = cm_out.box.max_y;
      out_pack[O_CX_LSB +: COORD_W]   = cm_out.center_x;
      out_pack[O_CY_LSB +: COORD_W]   = cm_out.center_y;
      out_pack[O_AREA_LSB +: AREA_W]  = cm_out.area;
      out_pack[O_FAR_LSB +: DIST_W]   = cm_out.far;
      out_pack[O_REACH_BIT]           = cm_out.reach_ok;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata    <= out_pack;
      m_axis_tuser[0] <= (cur_req == REQ_SAMPLE) ? 1'b0 : filled;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nscb_checker.sv
// Port-level checks for the nearest-site cell box top level, bound to it below.
// Depends on nscb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nscb_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tready,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [nscb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic [0:0]                       m_axis_tuser
);
  import nscb_pkg::*;

  // A result held by the receiver keeps its contents.
  `NSCB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                    "result changed while stalled")

  // In the first cycle after reset the block is ready and shows no result.
  `NSCB_ASSERT_IMPL(a_reset_idle, clk, 1'b0, $past(rst) && !rst,
                    s_axis_tready && !m_axis_tvalid, "not idle after reset")

  // A nonzero distance only comes with a sample, whose readout fields are zero.
  `NSCB_ASSERT_IMPL(a_sample_clean, clk, rst,
                    m_axis_tvalid && (m_axis_tdata[O_DIST_LSB +: DIST_W] != '0),
                    (m_axis_tdata[OUT_TDATA_W-1:O_MINX_LSB] == '0) && !m_axis_tuser[0],
                    "sample result carries readout fields")

  // A filled cell box is never inverted.
  `NSCB_ASSERT_IMPL(a_box_order, clk, rst, m_axis_tvalid && m_axis_tuser[0],
                    ($signed(m_axis_tdata[O_MINX_LSB +: COORD_W]) <=
                     $signed(m_axis_tdata[O_MAXX_LSB +: COORD_W])) &&
                    ($signed(m_axis_tdata[O_MINY_LSB +: COORD_W]) <=
                     $signed(m_axis_tdata[O_MAXY_LSB +: COORD_W])),
                    "filled box inverted")

endmodule

bind nearest_site_cell_boxes_top nscb_checker u_nscb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
